// ----- sv/assert_macros.svh -----
// Assertion helpers. Each one is clocked on i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SFL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/sfl_pkg.sv -----
`default_nettype none
package sfl_pkg;
    localparam int MAX_RADIUS = 31;
    localparam int MAX_LINE   = 4096;
    localparam int PIX_W      = 8;
    localparam int CHANNELS   = 4;
    localparam int WEIGHT_W   = 17;
    localparam int IDX_W      = 6;
    localparam int RAD_W      = 5;
    localparam int FRAC_W     = 16;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PAD  = 4'b0010,
        S_CALC = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic                bcast;
        logic                shift;
        logic                shift_new;
        logic                load;
        logic [IDX_W-1:0]    load_idx;
        logic [WEIGHT_W-1:0] load_w;
    } t_cell_ctrl;
endpackage
`default_nettype wire

// ----- sv/sfl_if.sv -----
`default_nettype none
interface sfl_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [sfl_pkg::IDX_W-1:0]     weight_index;
    logic [sfl_pkg::WEIGHT_W-1:0]  weight_value;
    logic [sfl_pkg::PIX_W-1:0]     pixel_b;
    logic [sfl_pkg::PIX_W-1:0]     pixel_g;
    logic [sfl_pkg::PIX_W-1:0]     pixel_r;
    logic [sfl_pkg::PIX_W-1:0]     pixel_a;
    logic                          line_end;
    modport source (output valid, func, weight_index, weight_value, pixel_b, pixel_g,
                    pixel_r, pixel_a, line_end, input ready);
    modport sink (input valid, func, weight_index, weight_value, pixel_b, pixel_g,
                  pixel_r, pixel_a, line_end, output ready);
endinterface

interface sfl_out_if;
    logic                      valid;
    logic                      ready;
    logic [sfl_pkg::PIX_W-1:0] out_b;
    logic [sfl_pkg::PIX_W-1:0] out_g;
    logic [sfl_pkg::PIX_W-1:0] out_r;
    logic [sfl_pkg::PIX_W-1:0] out_a;
    logic                      out_last;
    modport source (output valid, out_b, out_g, out_r, out_a, out_last, input ready);
    modport sink (input valid, out_b, out_g, out_r, out_a, out_last, output ready);
endinterface

interface sfl_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [sfl_pkg::RAD_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- sv/sfl_cell.sv -----
`default_nettype none
module sfl_cell #(
    parameter int INDEX = 0,
    parameter int TW    = 6,
    parameter int SUM_W = 31
) (
    input  wire logic                                           i_clk,
    input  wire sfl_pkg::t_cell_ctrl                            i_ctrl,
    input  wire logic [TW-1:0]                                  i_top,
    input  wire logic [sfl_pkg::CHANNELS*sfl_pkg::PIX_W-1:0]    i_px_in,
    input  wire logic [sfl_pkg::CHANNELS*sfl_pkg::PIX_W-1:0]    i_px_next,
    input  wire logic [sfl_pkg::CHANNELS-1:0][SUM_W-1:0]        i_sum_prev,
    output logic      [sfl_pkg::CHANNELS*sfl_pkg::PIX_W-1:0]    o_px,
    output logic      [sfl_pkg::CHANNELS-1:0][SUM_W-1:0]        o_sum
);
    localparam int PW = sfl_pkg::PIX_W;
    localparam int WW = sfl_pkg::WEIGHT_W;

    logic [WW-1:0]                             r_w;
    logic [sfl_pkg::CHANNELS*PW-1:0]           r_px;
    logic [sfl_pkg::CHANNELS*PW-1:0]           n_px;
    logic [sfl_pkg::CHANNELS-1:0][WW+PW-1:0]   r_prod;
    logic [sfl_pkg::CHANNELS-1:0][SUM_W-1:0]   r_sum;
    logic                                      w_is_top;
    logic                                      w_active;

    assign w_is_top = (i_top == TW'(INDEX));
    assign w_active = (TW'(INDEX) <= i_top);

    always_comb begin
        n_px = r_px;
        if (i_ctrl.bcast) begin
            n_px = i_px_in;
        end else if (i_ctrl.shift) begin
            if (w_is_top) begin
                n_px = i_ctrl.shift_new ? i_px_in : r_px;
            end else begin
                n_px = i_px_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && (32'(i_ctrl.load_idx) == INDEX)) begin
            r_w <= i_ctrl.load_w;
        end
        r_px <= n_px;
        for (int c = 0; c < sfl_pkg::CHANNELS; c++) begin
            r_prod[c] <= r_w * r_px[c*PW +: PW];
            r_sum[c]  <= i_sum_prev[c] + (w_active ? SUM_W'(r_prod[c]) : '0);
        end
    end

    assign o_px  = r_px;
    assign o_sum = r_sum;
endmodule
`default_nettype wire

// ----- sv/separable_gaussian_fir_line_top.sv -----
// Gaussian line filter with clamp to edge, four 8-bit channels per pixel.
// i_cfg writes the radius (reset 1); write it only while the block is idle.
// i_pix carries requests: func 0 loads one Q1.16 tap weight, func 1 is a
// pixel of the current line, with line_end on the last pixel of a line.
// o_res returns filtered pixels, out_last on the final one of a line.
// The first pixel of a line fills the whole row of cells, which gives the
// left edge; the right edge is made by shifting the last pixel in again.
// The weighted sum of each result ripples through the row of 2*MAX_RADIUS+1
// cells one cell per cycle. A line end may first add extra shifts in S_PAD,
// which repeat the last pixel, before its first result.
// Pixel requests are taken only while no result is in progress; weight
// loads leave the block idle. A result waits in the output register for as long
// as the receiver stalls, and the block takes no request meanwhile.
// Reset clears the control state and the line position and sets the radius to 1.
`default_nettype none
module separable_gaussian_fir_line_top #(
    parameter int MAX_RADIUS = sfl_pkg::MAX_RADIUS,
    parameter int MAX_LINE   = sfl_pkg::MAX_LINE
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sfl_in_if.sink    i_pix,
    sfl_cfg_if.sink   i_cfg,
    sfl_out_if.source o_res
);
    `include "assert_macros.svh"

    localparam int N      = 2 * MAX_RADIUS + 1;
    localparam int TW     = $clog2(N);
    localparam int RW     = $clog2(MAX_RADIUS + 1);
    localparam int LW     = $clog2(MAX_LINE);
    localparam int PW     = sfl_pkg::PIX_W;
    localparam int NCH    = sfl_pkg::CHANNELS;
    localparam int SUM_W  = sfl_pkg::WEIGHT_W + PW + $clog2(N);
    localparam int CW     = $clog2(N + 3);
    localparam int CALC_LAST = N + 2;

    sfl_pkg::t_state                r_state, n_state;
    logic [sfl_pkg::RAD_W-1:0]      r_radius;
    logic [RW-1:0]                  r_lr, n_lr;
    logic [LW-1:0]                  r_pos, n_pos;
    logic [LW-1:0]                  r_next, n_next;
    logic [LW:0]                    r_pend, n_pend;
    logic [RW-1:0]                  r_pad, n_pad;
    logic [CW-1:0]                  r_cnt, n_cnt;
    logic [NCH-1:0][PW-1:0]         r_out, n_out;
    logic                           r_last, n_last;

    sfl_pkg::t_cell_ctrl            w_ctrl;
    logic [NCH*PW-1:0]              w_px_in;
    logic [RW-1:0]                  w_rad_sat;
    logic [RW-1:0]                  w_lr_eff;
    logic                           w_end;
    logic [LW+1:0]                  w_reach;
    logic [TW-1:0]                  w_top;
    logic [N-1:0][NCH*PW-1:0]       w_px;
    logic [N-1:0][NCH-1:0][SUM_W-1:0] w_sum;
    logic [SUM_W-sfl_pkg::FRAC_W-1:0] w_int [NCH];

    assign w_px_in   = {i_pix.pixel_a, i_pix.pixel_r, i_pix.pixel_g, i_pix.pixel_b};
    assign w_rad_sat = (32'(r_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_radius);
    assign w_lr_eff  = (r_pos == '0) ? w_rad_sat : r_lr;
    assign w_end     = i_pix.line_end || (32'(r_pos) >= MAX_LINE - 1);
    assign w_reach   = (LW+2)'(r_next) + (LW+2)'(w_lr_eff);
    assign w_top     = TW'({r_lr, 1'b0});

    assign i_pix.ready = (r_state == sfl_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = (r_state == sfl_pkg::S_OUT);
    assign o_res.out_b = r_out[0];
    assign o_res.out_g = r_out[1];
    assign o_res.out_r = r_out[2];
    assign o_res.out_a = r_out[3];
    assign o_res.out_last = r_last;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_int[c] = w_sum[N-1][c][SUM_W-1:sfl_pkg::FRAC_W];
        end
    end

    always_comb begin
        n_state = r_state;
        n_lr    = r_lr;
        n_pos   = r_pos;
        n_next  = r_next;
        n_pend  = r_pend;
        n_pad   = r_pad;
        n_cnt   = r_cnt;
        n_out   = r_out;
        n_last  = r_last;
        w_ctrl  = '0;
        w_ctrl.load_idx = i_pix.weight_index;
        w_ctrl.load_w   = i_pix.weight_value;
        case (r_state)
            sfl_pkg::S_IDLE: begin
                if (i_pix.valid) begin
                    if (!i_pix.func) begin
                        w_ctrl.load = 1'b1;
                    end else begin
                        if (r_pos == '0) begin
                            w_ctrl.bcast = 1'b1;
                            n_lr = w_rad_sat;
                        end else begin
                            w_ctrl.shift     = 1'b1;
                            w_ctrl.shift_new = 1'b1;
                        end
                        n_cnt = '0;
                        if (w_end) begin
                            n_pend = (LW+1)'(r_pos) - (LW+1)'(r_next) + 1'b1;
                            n_pos  = '0;
                            n_next = '0;
                            if (w_reach > (LW+2)'(r_pos)) begin
                                n_pad   = RW'(w_reach - (LW+2)'(r_pos));
                                n_state = sfl_pkg::S_PAD;
                            end else begin
                                n_state = sfl_pkg::S_CALC;
                            end
                        end else begin
                            n_pos = r_pos + 1'b1;
                            if ((LW+1)'(r_pos) >= (LW+1)'(w_lr_eff)) begin
                                n_pend  = (LW+1)'(1);
                                n_next  = r_pos - LW'(w_lr_eff) + 1'b1;
                                n_state = sfl_pkg::S_CALC;
                            end
                        end
                    end
                end
            end
            sfl_pkg::S_PAD: begin
                w_ctrl.shift = 1'b1;
                n_pad = r_pad - 1'b1;
                if (r_pad == RW'(1)) begin
                    n_state = sfl_pkg::S_CALC;
                end
            end
            sfl_pkg::S_CALC: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(CALC_LAST)) begin
                    for (int c = 0; c < NCH; c++) begin
                        n_out[c] = (w_int[c] > 255) ? 8'hFF : w_int[c][PW-1:0];
                    end
                    n_last  = (r_pend == (LW+1)'(1)) && (r_pos == '0);
                    n_state = sfl_pkg::S_OUT;
                end
            end
            sfl_pkg::S_OUT: begin
                if (o_res.ready) begin
                    n_pend = r_pend - 1'b1;
                    if (r_pend == (LW+1)'(1)) begin
                        n_state = sfl_pkg::S_IDLE;
                    end else begin
                        w_ctrl.shift = 1'b1;
                        n_cnt   = '0;
                        n_state = sfl_pkg::S_CALC;
                    end
                end
            end
            default: begin
                n_state = sfl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sfl_pkg::S_IDLE;
            r_radius <= sfl_pkg::RAD_W'(1);
            r_lr     <= '0;
            r_pos    <= '0;
            r_next   <= '0;
            r_pend   <= '0;
            r_pad    <= '0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_radius <= i_cfg.data;
            end
            r_lr   <= n_lr;
            r_pos  <= n_pos;
            r_next <= n_next;
            r_pend <= n_pend;
            r_pad  <= n_pad;
            r_cnt  <= n_cnt;
        end
        r_out  <= n_out;
        r_last <= n_last;
    end

    for (genvar j = 0; j < N; j++) begin : g_cell
        logic [NCH*PW-1:0]         w_nb;
        logic [NCH-1:0][SUM_W-1:0] w_prev;
        if (j == N - 1) begin : g_end
            assign w_nb = w_px_in;
        end else begin : g_mid
            assign w_nb = w_px[j+1];
        end
        if (j == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_rest
            assign w_prev = w_sum[j-1];
        end
        sfl_cell #(
            .INDEX (j),
            .TW    (TW),
            .SUM_W (SUM_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_top      (w_top),
            .i_px_in    (w_px_in),
            .i_px_next  (w_nb),
            .i_sum_prev (w_prev),
            .o_px       (w_px[j]),
            .o_sum      (w_sum[j])
        );
    end

    `SFL_ASSERT_SAME(a_idle_no_pending, r_state == sfl_pkg::S_IDLE, r_pend == '0)
    `SFL_ASSERT_NEXT(a_more_results, o_res.valid && o_res.ready && (r_pend > (LW+1)'(1)), r_state == sfl_pkg::S_CALC)
    `SFL_ASSERT_SAME(a_last_line_reset, o_res.valid && r_last, r_pos == '0)
endmodule
`default_nettype wire
